/* rtl/rpg_pkg.sv */
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared widths, constants, register indexes and types of the rainbow
// pixel generator.
// ----------------------------------------------------------------------------
package rpg_pkg;

   // Field widths
   localparam int ELAPSED_W = 64;
   localparam int STRIP_W   = 8;
   localparam int LED_W     = 16;
   localparam int LUMA_W    = 9;
   localparam int WORD_W    = 32;
   localparam int CHAN_W    = 8;
   localparam int ADDR_W    = 5;

   // Scene constants
   localparam longint unsigned CYCLE_US      = 64'd8000000;
   localparam longint unsigned PERIOD_PIXELS = 64'd64;
   localparam longint unsigned HUE_STEPS     = 64'd1536;
   localparam int unsigned     LUMA_ONE      = 256;
   localparam int unsigned     ROUND_HALF    = 128;
   localparam int unsigned     CHAN_MAX      = 255;

   localparam int HUE_W = $clog2(HUE_STEPS);
   localparam logic [HUE_W-1:0] HUE_VAL = HUE_W'(HUE_STEPS);

   // Elapsed time is reduced modulo the cycle one slice at a time
   localparam int CHUNK_W    = 16;
   localparam int NUM_CHUNKS = ELAPSED_W / CHUNK_W;
   localparam int CYC_W      = $clog2(CYCLE_US + 64'd1);
   localparam int CX_W       = CYC_W + CHUNK_W;
   localparam int CR_W       = CHUNK_W + 2;
   localparam logic [CYC_W-1:0] CYC_VAL   = CYC_W'(CYCLE_US);
   localparam logic [CR_W-1:0]  CYC_RECIP = CR_W'((64'd1 << CX_W) / CYCLE_US);

   // Motion: (rem * HUE_STEPS) / CYCLE_US through a reciprocal
   localparam int MY_W = CYC_W + HUE_W;
   localparam int MK_W = 2 * HUE_W + 2;
   localparam longint unsigned MOT_RECIP = (64'd1 << MY_W) / CYCLE_US;
   localparam logic [MK_W-1:0] MOT_K     = MK_W'(HUE_STEPS * MOT_RECIP);
   localparam int MOTION_LAT = 2 * NUM_CHUNKS + 2;

   // Spatial period
   localparam int PER_W = $clog2(PERIOD_PIXELS + 64'd1);
   localparam int PR_W  = WORD_W + 1;
   localparam logic [PER_W-1:0] PER_VAL      = PER_W'(PERIOD_PIXELS);
   localparam logic [PR_W-1:0]  PER_RECIP    = PR_W'((64'd1 << WORD_W) / PERIOD_PIXELS);
   localparam logic [HUE_W-1:0] HUE_STEP_PER = HUE_W'(HUE_STEPS / PERIOD_PIXELS);
   localparam int SIDE_DLY = MOTION_LAT - 2;

   // Seed hue: seed mod HUE_STEPS through a reciprocal
   localparam int SR_W = WORD_W - HUE_W + 2;
   localparam logic [SR_W-1:0] SEED_RECIP = SR_W'((64'd1 << WORD_W) / HUE_STEPS);

   typedef enum logic [2:0] {
      REG_LUMINANCE       = 3'd0,
      REG_SEED_VALUE      = 3'd1,
      REG_STRIP_OFFSET    = 3'd2,
      REG_STRIPS_IN_USE   = 3'd3,
      REG_LEDS_EACH_STRIP = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      SEC_RISE_GREEN = 3'd0,
      SEC_FALL_RED   = 3'd1,
      SEC_RISE_BLUE  = 3'd2,
      SEC_FALL_GREEN = 3'd3,
      SEC_RISE_RED   = 3'd4,
      SEC_FALL_BLUE  = 3'd5
   } sector_type;

   typedef struct packed {
      logic [LUMA_W-1:0]  luminance;
      logic [HUE_W-1:0]   seed_hue;
      logic [WORD_W-1:0]  strip_offset;
      logic [STRIP_W-1:0] strips_in_use;
      logic [LED_W-1:0]   leds_each_strip;
   } cfg_type;

endpackage

/* rtl/rpg_csr.sv */
// ----------------------------------------------------------------------------
// rpg_csr
// Configuration registers behind the APB port, plus the seed hue phase
// derived from the seed register through a quotient and a hue register.
// ----------------------------------------------------------------------------
module rpg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rpg_pkg::ADDR_W-1:0]   paddr,
   input  logic [rpg_pkg::WORD_W-1:0]   pwdata,
   output logic [rpg_pkg::WORD_W-1:0]   prdata,
   output logic                         pready,
   output rpg_pkg::cfg_type             cfg
);

   logic [rpg_pkg::LUMA_W-1:0]  luminance_ff;
   logic [rpg_pkg::WORD_W-1:0]  seed_value_ff;
   logic [rpg_pkg::WORD_W-1:0]  strip_offset_ff;
   logic [rpg_pkg::STRIP_W-1:0] strips_in_use_ff;
   logic [rpg_pkg::LED_W-1:0]   leds_each_strip_ff;
   logic [rpg_pkg::SR_W-1:0]    seed_q_ff;
   logic [rpg_pkg::SR_W-1:0]    seed_q_in;
   logic [rpg_pkg::HUE_W-1:0]   seed_hue_ff;
   logic [rpg_pkg::HUE_W-1:0]   seed_hue_in;
   logic [rpg_pkg::WORD_W+rpg_pkg::SR_W-1:0] seed_prod;
   logic [rpg_pkg::WORD_W-1:0]  seed_diff;
   logic [rpg_pkg::WORD_W-1:0]  seed_fix;
   rpg_pkg::reg_index_type      index;
   logic                        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = rpg_pkg::reg_index_type'(paddr[rpg_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         luminance_ff       <= rpg_pkg::LUMA_W'(rpg_pkg::LUMA_ONE);
         seed_value_ff      <= '0;
         strip_offset_ff    <= '0;
         strips_in_use_ff   <= rpg_pkg::STRIP_W'(1);
         leds_each_strip_ff <= rpg_pkg::LED_W'(1);
      end else if (wr_en) begin
         unique case (index)
            rpg_pkg::REG_LUMINANCE:       luminance_ff <= pwdata[rpg_pkg::LUMA_W-1:0];
            rpg_pkg::REG_SEED_VALUE:      seed_value_ff <= pwdata;
            rpg_pkg::REG_STRIP_OFFSET:    strip_offset_ff <= pwdata;
            rpg_pkg::REG_STRIPS_IN_USE:   strips_in_use_ff <= pwdata[rpg_pkg::STRIP_W-1:0];
            rpg_pkg::REG_LEDS_EACH_STRIP: leds_each_strip_ff <= pwdata[rpg_pkg::LED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         rpg_pkg::REG_LUMINANCE:       prdata = rpg_pkg::WORD_W'(luminance_ff);
         rpg_pkg::REG_SEED_VALUE:      prdata = seed_value_ff;
         rpg_pkg::REG_STRIP_OFFSET:    prdata = strip_offset_ff;
         rpg_pkg::REG_STRIPS_IN_USE:   prdata = rpg_pkg::WORD_W'(strips_in_use_ff);
         rpg_pkg::REG_LEDS_EACH_STRIP: prdata = rpg_pkg::WORD_W'(leds_each_strip_ff);
         default:                      prdata = '0;
      endcase
   end

   // Quotient estimate is exact or one low; the second stage corrects it
   always_comb begin
      seed_prod = (rpg_pkg::WORD_W + rpg_pkg::SR_W)'(seed_value_ff)
                * (rpg_pkg::WORD_W + rpg_pkg::SR_W)'(rpg_pkg::SEED_RECIP);
      seed_q_in = seed_prod[rpg_pkg::WORD_W +: rpg_pkg::SR_W];
      seed_diff = seed_value_ff
                - rpg_pkg::WORD_W'(seed_q_ff) * rpg_pkg::WORD_W'(rpg_pkg::HUE_VAL);
      if (seed_diff >= rpg_pkg::WORD_W'(rpg_pkg::HUE_VAL)) begin
         seed_fix = seed_diff - rpg_pkg::WORD_W'(rpg_pkg::HUE_VAL);
      end else begin
         seed_fix = seed_diff;
      end
      seed_hue_in = seed_fix[rpg_pkg::HUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      seed_q_ff   <= seed_q_in;
      seed_hue_ff <= seed_hue_in;
   end

   assign cfg.luminance       = luminance_ff;
   assign cfg.seed_hue        = seed_hue_ff;
   assign cfg.strip_offset    = strip_offset_ff;
   assign cfg.strips_in_use   = strips_in_use_ff;
   assign cfg.leds_each_strip = leds_each_strip_ff;

endmodule

/* rtl/rpg_motion.sv */
// ----------------------------------------------------------------------------
// rpg_motion
// Pipelined motion phase: elapsed time modulo the cycle, reduced one 16-bit
// slice per two stages, then scaled to the hue wheel through a reciprocal.
// ----------------------------------------------------------------------------
module rpg_motion (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rpg_pkg::ELAPSED_W-1:0] in_elapsed,
   output logic                          out_valid,
   output logic [rpg_pkg::HUE_W-1:0]     out_motion
);

   localparam int PA_W = rpg_pkg::CX_W + rpg_pkg::CR_W;
   localparam int P2_W = rpg_pkg::CYC_W + rpg_pkg::MK_W;

   logic                          a_valid_ff   [rpg_pkg::NUM_CHUNKS];
   logic [rpg_pkg::ELAPSED_W-1:0] a_elapsed_ff [rpg_pkg::NUM_CHUNKS];
   logic [rpg_pkg::CX_W-1:0]      a_x_ff       [rpg_pkg::NUM_CHUNKS];
   logic [rpg_pkg::CHUNK_W-1:0]   a_q_ff       [rpg_pkg::NUM_CHUNKS];
   logic                          b_valid_ff   [rpg_pkg::NUM_CHUNKS];
   logic [rpg_pkg::ELAPSED_W-1:0] b_elapsed_ff [rpg_pkg::NUM_CHUNKS];
   logic [rpg_pkg::CYC_W-1:0]     b_rem_ff     [rpg_pkg::NUM_CHUNKS];

   for (genvar k = 0; k < rpg_pkg::NUM_CHUNKS; k++) begin : g_chunk
      logic                          val_prev;
      logic [rpg_pkg::ELAPSED_W-1:0] el_prev;
      logic [rpg_pkg::CYC_W-1:0]     rem_prev;
      logic [rpg_pkg::CX_W-1:0]      x_in;
      logic [PA_W-1:0]               prod;
      logic [rpg_pkg::CHUNK_W-1:0]   q_in;
      logic [rpg_pkg::CX_W-1:0]      diff;
      logic [rpg_pkg::CX_W-1:0]      fix;
      logic [rpg_pkg::CYC_W-1:0]     rem_in;

      if (k == 0) begin : g_first
         assign val_prev = in_valid;
         assign el_prev  = in_elapsed;
         assign rem_prev = '0;
      end else begin : g_next
         assign val_prev = b_valid_ff[k-1];
         assign el_prev  = b_elapsed_ff[k-1];
         assign rem_prev = b_rem_ff[k-1];
      end

      // Estimate the slice quotient; exact or one low
      always_comb begin
         x_in = {rem_prev,
                 el_prev[rpg_pkg::ELAPSED_W-1-k*rpg_pkg::CHUNK_W -: rpg_pkg::CHUNK_W]};
         prod = PA_W'(x_in) * PA_W'(rpg_pkg::CYC_RECIP);
         q_in = prod[rpg_pkg::CX_W +: rpg_pkg::CHUNK_W];
      end

      // Subtract the multiple and correct once
      always_comb begin
         diff = a_x_ff[k]
              - rpg_pkg::CX_W'(a_q_ff[k]) * rpg_pkg::CX_W'(rpg_pkg::CYC_VAL);
         if (diff >= rpg_pkg::CX_W'(rpg_pkg::CYC_VAL)) begin
            fix = diff - rpg_pkg::CX_W'(rpg_pkg::CYC_VAL);
         end else begin
            fix = diff;
         end
         rem_in = fix[rpg_pkg::CYC_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
            b_valid_ff[k] <= 1'b0;
         end else begin
            a_valid_ff[k] <= val_prev;
            b_valid_ff[k] <= a_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         a_elapsed_ff[k] <= el_prev;
         a_x_ff[k]       <= x_in;
         a_q_ff[k]       <= q_in;
         b_elapsed_ff[k] <= a_elapsed_ff[k];
         b_rem_ff[k]     <= rem_in;
      end
   end

   logic                      m1_valid_ff;
   logic [rpg_pkg::CYC_W-1:0] m1_rem_ff;
   logic [rpg_pkg::HUE_W-1:0] m1_q_ff;
   logic [rpg_pkg::HUE_W-1:0] m1_q_in;
   logic [P2_W-1:0]           m1_prod;
   logic                      motion_valid_ff;
   logic [rpg_pkg::HUE_W-1:0] motion_ff;
   logic [rpg_pkg::HUE_W-1:0] motion_in;
   logic [rpg_pkg::MY_W-1:0]  m2_y;
   logic [rpg_pkg::MY_W-1:0]  m2_rem;

   always_comb begin
      m1_prod = P2_W'(b_rem_ff[rpg_pkg::NUM_CHUNKS-1]) * P2_W'(rpg_pkg::MOT_K);
      m1_q_in = m1_prod[rpg_pkg::MY_W +: rpg_pkg::HUE_W];
   end

   // Bump the estimate when the leftover still holds a whole cycle
   always_comb begin
      m2_y      = rpg_pkg::MY_W'(m1_rem_ff) * rpg_pkg::MY_W'(rpg_pkg::HUE_VAL);
      m2_rem    = m2_y - rpg_pkg::MY_W'(m1_q_ff) * rpg_pkg::MY_W'(rpg_pkg::CYC_VAL);
      motion_in = m1_q_ff
                + rpg_pkg::HUE_W'(m2_rem >= rpg_pkg::MY_W'(rpg_pkg::CYC_VAL));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff     <= 1'b0;
         motion_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff     <= b_valid_ff[rpg_pkg::NUM_CHUNKS-1];
         motion_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_rem_ff <= b_rem_ff[rpg_pkg::NUM_CHUNKS-1];
      m1_q_ff   <= m1_q_in;
      motion_ff <= motion_in;
   end

   assign out_valid  = motion_valid_ff;
   assign out_motion = motion_ff;

endmodule

/* rtl/rpg_color.sv */
// ----------------------------------------------------------------------------
// rpg_color
// Final hue, six-sector wheel to RGB and luminance scaling into the result
// register.
// ----------------------------------------------------------------------------
module rpg_color (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_ok,
   input  logic [rpg_pkg::HUE_W-1:0]    in_motion,
   input  logic [rpg_pkg::HUE_W-1:0]    in_spatial,
   input  rpg_pkg::cfg_type             cfg,
   output logic                         out_valid,
   output logic [rpg_pkg::CHAN_W-1:0]   out_red,
   output logic [rpg_pkg::CHAN_W-1:0]   out_green,
   output logic [rpg_pkg::CHAN_W-1:0]   out_blue,
   output logic                         out_pixel_valid
);

   localparam int HS_W = rpg_pkg::HUE_W + 2;

   function automatic logic [rpg_pkg::CHAN_W-1:0] scale_chan(
      input logic [rpg_pkg::CHAN_W-1:0] c,
      input logic [rpg_pkg::LUMA_W-1:0] lum
   );
      logic [rpg_pkg::CHAN_W+rpg_pkg::LUMA_W-1:0] prod;
      logic [rpg_pkg::LUMA_W-1:0]                 v;
      prod = (rpg_pkg::CHAN_W + rpg_pkg::LUMA_W)'(c) * (rpg_pkg::CHAN_W + rpg_pkg::LUMA_W)'(lum)
           + (rpg_pkg::CHAN_W + rpg_pkg::LUMA_W)'(rpg_pkg::ROUND_HALF);
      v = prod[rpg_pkg::CHAN_W +: rpg_pkg::LUMA_W];
      if (v > rpg_pkg::LUMA_W'(rpg_pkg::CHAN_MAX)) begin
         return rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX);
      end
      return v[rpg_pkg::CHAN_W-1:0];
   endfunction

   logic                      hue_valid_ff;
   logic                      hue_ok_ff;
   logic                      hue_ok_in;
   logic [rpg_pkg::HUE_W-1:0] hue_ff;
   logic [rpg_pkg::HUE_W-1:0] hue_in;
   logic [HS_W-1:0]           hue_sum;
   logic [HS_W-1:0]           hue_wrap;

   always_comb begin
      hue_sum = HS_W'(in_spatial) + HS_W'(cfg.seed_hue) + HS_W'(rpg_pkg::HUE_VAL)
              - HS_W'(in_motion);
      priority if (hue_sum >= HS_W'(2) * HS_W'(rpg_pkg::HUE_VAL)) begin
         hue_wrap = hue_sum - HS_W'(2) * HS_W'(rpg_pkg::HUE_VAL);
      end else if (hue_sum >= HS_W'(rpg_pkg::HUE_VAL)) begin
         hue_wrap = hue_sum - HS_W'(rpg_pkg::HUE_VAL);
      end else begin
         hue_wrap = hue_sum;
      end
      hue_in    = hue_wrap[rpg_pkg::HUE_W-1:0];
      hue_ok_in = in_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_valid_ff <= 1'b0;
      end else begin
         hue_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff    <= hue_in;
      hue_ok_ff <= hue_ok_in;
   end

   rpg_pkg::sector_type       sector;
   logic [rpg_pkg::CHAN_W-1:0] up;
   logic [rpg_pkg::CHAN_W-1:0] down;
   logic [rpg_pkg::CHAN_W-1:0] wr;
   logic [rpg_pkg::CHAN_W-1:0] wg;
   logic [rpg_pkg::CHAN_W-1:0] wb;
   logic [rpg_pkg::CHAN_W-1:0] red_in;
   logic [rpg_pkg::CHAN_W-1:0] green_in;
   logic [rpg_pkg::CHAN_W-1:0] blue_in;
   logic [rpg_pkg::CHAN_W-1:0] red_ff;
   logic [rpg_pkg::CHAN_W-1:0] green_ff;
   logic [rpg_pkg::CHAN_W-1:0] blue_ff;
   logic                       pixel_valid_ff;
   logic                       rsp_valid_ff;

   always_comb begin
      sector = rpg_pkg::sector_type'(hue_ff[rpg_pkg::HUE_W-1:rpg_pkg::CHAN_W]);
      up     = hue_ff[rpg_pkg::CHAN_W-1:0];
      down   = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX) - up;
      unique case (sector)
         rpg_pkg::SEC_RISE_GREEN: begin
            wr = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX); wg = up; wb = '0;
         end
         rpg_pkg::SEC_FALL_RED: begin
            wr = down; wg = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX); wb = '0;
         end
         rpg_pkg::SEC_RISE_BLUE: begin
            wr = '0; wg = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX); wb = up;
         end
         rpg_pkg::SEC_FALL_GREEN: begin
            wr = '0; wg = down; wb = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX);
         end
         rpg_pkg::SEC_RISE_RED: begin
            wr = up; wg = '0; wb = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX);
         end
         default: begin
            wr = rpg_pkg::CHAN_W'(rpg_pkg::CHAN_MAX); wg = '0; wb = down;
         end
      endcase
      // Drop the color of pixels outside the configured area or above full luminance
      if (hue_ok_ff) begin
         red_in   = scale_chan(wr, cfg.luminance);
         green_in = scale_chan(wg, cfg.luminance);
         blue_in  = scale_chan(wb, cfg.luminance);
      end else begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= hue_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      red_ff         <= red_in;
      green_ff       <= green_in;
      blue_ff        <= blue_in;
      pixel_valid_ff <= hue_ok_ff;
   end

   assign out_valid       = rsp_valid_ff;
   assign out_red         = red_ff;
   assign out_green       = green_ff;
   assign out_blue        = blue_ff;
   assign out_pixel_valid = pixel_valid_ff;

endmodule

/* rtl/rainbow_pixel_generator.sv */
// ----------------------------------------------------------------------------
// rainbow_pixel_generator
// Per-pixel color of a moving hue-wheel rainbow, one pixel per clock.
// ----------------------------------------------------------------------------
// A request is taken on every clock in which start is high; busy never
// rises. The result for a request appears on the rsp_ ports, for a single
// cycle marked by rsp_valid, in request order; the receiver must take it
// then, since nothing holds it. It passes the input register, then the
// reduction of the 64-bit elapsed time modulo the cycle period, two pipeline
// stages per 16-bit slice, followed by the scaling of the motion phase, the
// hue sum and the color stage. A write to the seed register reaches the hue
// phase through the quotient and hue registers behind it.
// ----------------------------------------------------------------------------
module rainbow_pixel_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rpg_pkg::ELAPSED_W-1:0] req_stamp_us,
   input  logic [rpg_pkg::STRIP_W-1:0]   req_strip_index,
   input  logic [rpg_pkg::LED_W-1:0]     req_led_index,
   output logic                          rsp_valid,
   output logic [rpg_pkg::CHAN_W-1:0]    rsp_red,
   output logic [rpg_pkg::CHAN_W-1:0]    rsp_green,
   output logic [rpg_pkg::CHAN_W-1:0]    rsp_blue,
   output logic                          rsp_pixel_valid,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rpg_pkg::ADDR_W-1:0]    paddr,
   input  logic [rpg_pkg::WORD_W-1:0]    pwdata,
   output logic [rpg_pkg::WORD_W-1:0]    prdata,
   output logic                          pready
);

   rpg_pkg::cfg_type cfg;

   rpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy = 1'b0;

   // Input register
   logic                          s0_valid_ff;
   logic [rpg_pkg::ELAPSED_W-1:0] s0_elapsed_ff;
   logic [rpg_pkg::WORD_W-1:0]    s0_global_ff;
   logic [rpg_pkg::WORD_W-1:0]    s0_global_in;
   logic                          s0_ok_ff;
   logic                          s0_ok_in;

   always_comb begin
      s0_global_in = cfg.strip_offset + rpg_pkg::WORD_W'(req_strip_index)
                   + rpg_pkg::WORD_W'(req_led_index);
      s0_ok_in = (req_strip_index < cfg.strips_in_use)
               && (req_led_index < cfg.leds_each_strip)
               && (cfg.luminance <= rpg_pkg::LUMA_W'(rpg_pkg::LUMA_ONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_elapsed_ff <= req_stamp_us;
      s0_global_ff  <= s0_global_in;
      s0_ok_ff      <= s0_ok_in;
   end

   // Spatial hue: global index modulo the pixel period, times the hue step
   logic [rpg_pkg::WORD_W+rpg_pkg::PR_W-1:0] g1_prod;
   logic [rpg_pkg::WORD_W-1:0] g1_q_ff;
   logic [rpg_pkg::WORD_W-1:0] g1_q_in;
   logic [rpg_pkg::WORD_W-1:0] g1_global_ff;
   logic                       g1_ok_ff;
   logic [rpg_pkg::WORD_W-1:0] g2_diff;
   logic [rpg_pkg::WORD_W-1:0] g2_fix;
   logic [rpg_pkg::HUE_W-1:0]  spatial_in;
   logic [rpg_pkg::HUE_W-1:0]  spatial_ff;
   logic                       g2_ok_ff;

   always_comb begin
      g1_prod = (rpg_pkg::WORD_W + rpg_pkg::PR_W)'(s0_global_ff)
              * (rpg_pkg::WORD_W + rpg_pkg::PR_W)'(rpg_pkg::PER_RECIP);
      g1_q_in = g1_prod[rpg_pkg::WORD_W +: rpg_pkg::WORD_W];
   end

   always_comb begin
      g2_diff = g1_global_ff
              - g1_q_ff * rpg_pkg::WORD_W'(rpg_pkg::PER_VAL);
      if (g2_diff >= rpg_pkg::WORD_W'(rpg_pkg::PER_VAL)) begin
         g2_fix = g2_diff - rpg_pkg::WORD_W'(rpg_pkg::PER_VAL);
      end else begin
         g2_fix = g2_diff;
      end
      spatial_in = rpg_pkg::HUE_W'(g2_fix[rpg_pkg::PER_W-1:0]) * rpg_pkg::HUE_STEP_PER;
   end

   always_ff @(posedge clock) begin
      g1_q_ff      <= g1_q_in;
      g1_global_ff <= s0_global_ff;
      g1_ok_ff     <= s0_ok_ff;
      spatial_ff   <= spatial_in;
      g2_ok_ff     <= g1_ok_ff;
   end

   // Hold the spatial hue until the motion phase catches up
   logic [rpg_pkg::HUE_W-1:0] dly_spatial_ff [rpg_pkg::SIDE_DLY];
   logic                      dly_ok_ff      [rpg_pkg::SIDE_DLY];

   always_ff @(posedge clock) begin
      dly_spatial_ff[0] <= spatial_ff;
      dly_ok_ff[0]      <= g2_ok_ff;
      for (int i = 1; i < rpg_pkg::SIDE_DLY; i++) begin
         dly_spatial_ff[i] <= dly_spatial_ff[i-1];
         dly_ok_ff[i]      <= dly_ok_ff[i-1];
      end
   end

   logic                      motion_valid;
   logic [rpg_pkg::HUE_W-1:0] motion;

   rpg_motion u_motion (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s0_valid_ff),
      .in_elapsed (s0_elapsed_ff),
      .out_valid  (motion_valid),
      .out_motion (motion)
   );

   rpg_color u_color (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (motion_valid),
      .in_ok           (dly_ok_ff[rpg_pkg::SIDE_DLY-1]),
      .in_motion       (motion),
      .in_spatial      (dly_spatial_ff[rpg_pkg::SIDE_DLY-1]),
      .cfg             (cfg),
      .out_valid       (rsp_valid),
      .out_red         (rsp_red),
      .out_green       (rsp_green),
      .out_blue        (rsp_blue),
      .out_pixel_valid (rsp_pixel_valid)
   );

endmodule
